[rtl/letter_run_length_encoder_top_defines.svh]
// assertion helpers for the letter run-length encoder
`ifndef LETTER_RUN_LENGTH_ENCODER_TOP_DEFINES_SVH
`define LETTER_RUN_LENGTH_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define LRLE_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("lrle assertion failed");
// condition must never be seen at a clock edge out of reset
`define LRLE_ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("lrle forbidden condition seen");
`else
`define LRLE_ASSERT(label, clk, rstn, prop)
`define LRLE_ASSERT_NEVER(label, clk, rstn, cond)
`endif

`endif

[rtl/lrle_pkg.sv]
package lrle_pkg;

  // ascii codes used by the encoder
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [3:0] BCD_NINE     = 4'd9;

  // per-run control carried through the queue
  typedef struct packed {
    logic [7:0] letter;
    logic       last;
    logic       done;
  } lrle_tag_t;

  // decimal digits needed for the largest count of a given width
  function automatic int dec_digits(int bits);
    longint unsigned v;
    int n;
    v = (64'd1 << bits) - 64'd1;
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 64'd0) begin
        n++;
        v = v / 10;
      end
    end
    return n;
  endfunction

endpackage

[rtl/lrle_front.sv]
module lrle_front import lrle_pkg::*; #(
  parameter int COUNT_BITS = 16,
  parameter int NUM_DIGITS = 5,
  parameter int DIG_W      = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  in_byte_i,
  input  logic                        end_of_string_i,
  output logic                        push_o,
  input  logic                        push_full_i,
  output lrle_tag_t                   push_tag_o,
  output logic [NUM_DIGITS-1:0][3:0]  push_digits_o,
  output logic [DIG_W-1:0]            push_ndig_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // run state
  logic                       active_q, active_d;
  logic [7:0]                 letter_q, letter_d;
  logic [COUNT_BITS-1:0]      bin_q, bin_d;
  logic [NUM_DIGITS-1:0][3:0] bcd_q, bcd_d;
  logic [DIG_W-1:0]           ndig_q, ndig_d;
  // second run of one request, waiting for its queue slot
  logic                       pend_q, pend_d;
  logic [7:0]                 pend_letter_q, pend_letter_d;

  logic                       accept, is_let, close_old, emit_new;
  logic                       nxt_active;
  logic [7:0]                 nxt_letter;
  logic [COUNT_BITS-1:0]      nxt_bin;
  logic [NUM_DIGITS-1:0][3:0] nxt_bcd, bcd_inc, bcd_one;
  logic [DIG_W-1:0]           nxt_ndig, ndig_inc;

  assign in_stall_o = pend_q | push_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_let     = in_byte_i inside {[CHAR_UPPER_A:CHAR_UPPER_Z],
                                        [CHAR_LOWER_A:CHAR_LOWER_Z]};
  assign close_old  = active_q & (~is_let | (in_byte_i != letter_q));

  // decimal increment of the run count, one digit carry at a time
  always_comb begin
    logic carry;
    carry   = 1'b1;
    bcd_inc = bcd_q;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (carry) begin
        if (bcd_q[i] == BCD_NINE) begin
          bcd_inc[i] = 4'd0;
        end else begin
          bcd_inc[i] = bcd_q[i] + 4'd1;
          carry      = 1'b0;
        end
      end
    end
    ndig_inc = ndig_q;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if ((DIG_W'(i) == ndig_q) && (bcd_inc[i] != 4'd0)) begin
        ndig_inc = ndig_q + DIG_W'(1);
      end
    end
    bcd_one    = '0;
    bcd_one[0] = 4'd1;
  end

  // run state after this request, before the end of string clears it
  always_comb begin
    nxt_active = active_q;
    nxt_letter = letter_q;
    nxt_bin    = bin_q;
    nxt_bcd    = bcd_q;
    nxt_ndig   = ndig_q;
    if (is_let) begin
      if (!active_q || close_old) begin
        nxt_active = 1'b1;
        nxt_letter = in_byte_i;
        nxt_bin    = COUNT_ONE;
        nxt_bcd    = bcd_one;
        nxt_ndig   = DIG_W'(1);
      end else if (bin_q != COUNT_MAX) begin
        nxt_bin  = bin_q + COUNT_ONE;
        nxt_bcd  = bcd_inc;
        nxt_ndig = ndig_inc;
      end
    end else begin
      nxt_active = 1'b0;
      nxt_letter = '0;
      nxt_bin    = '0;
      nxt_bcd    = '0;
      nxt_ndig   = '0;
    end
  end

  assign emit_new = end_of_string_i & nxt_active;

  // queue entry: waiting run first, then the closed run, then the final run
  always_comb begin
    push_o        = 1'b0;
    push_tag_o    = '0;
    push_digits_o = '0;
    push_ndig_o   = '0;
    if (pend_q) begin
      push_o            = ~push_full_i;
      push_tag_o.letter = pend_letter_q;
      push_tag_o.last   = 1'b1;
      push_tag_o.done   = 1'b1;
    end else if (close_old) begin
      push_o            = accept;
      push_tag_o.letter = letter_q;
      push_tag_o.last   = ~emit_new;
      push_tag_o.done   = end_of_string_i & ~emit_new;
      push_digits_o     = bcd_q;
      push_ndig_o       = (bin_q > COUNT_ONE) ? ndig_q : '0;
    end else begin
      push_o            = accept & emit_new;
      push_tag_o.letter = nxt_letter;
      push_tag_o.last   = 1'b1;
      push_tag_o.done   = 1'b1;
      push_digits_o     = nxt_bcd;
      push_ndig_o       = (nxt_bin > COUNT_ONE) ? nxt_ndig : '0;
    end
  end

  // next state on an accepted request
  always_comb begin
    active_d      = active_q;
    letter_d      = letter_q;
    bin_d         = bin_q;
    bcd_d         = bcd_q;
    ndig_d        = ndig_q;
    pend_d        = pend_q & push_full_i;
    pend_letter_d = pend_letter_q;
    if (accept) begin
      if (end_of_string_i) begin
        active_d = 1'b0;
        letter_d = '0;
        bin_d    = '0;
        bcd_d    = '0;
        ndig_d   = '0;
      end else begin
        active_d = nxt_active;
        letter_d = nxt_letter;
        bin_d    = nxt_bin;
        bcd_d    = nxt_bcd;
        ndig_d   = nxt_ndig;
      end
      if (close_old && emit_new) begin
        pend_d        = 1'b1;
        pend_letter_d = nxt_letter;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      letter_q      <= '0;
      bin_q         <= '0;
      bcd_q         <= '0;
      ndig_q        <= '0;
      pend_q        <= 1'b0;
      pend_letter_q <= '0;
    end else begin
      active_q      <= active_d;
      letter_q      <= letter_d;
      bin_q         <= bin_d;
      bcd_q         <= bcd_d;
      ndig_q        <= ndig_d;
      pend_q        <= pend_d;
      pend_letter_q <= pend_letter_d;
    end
  end

endmodule

[rtl/lrle_queue.sv]
module lrle_queue import lrle_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  input  logic             pop_i
);

  // two-entry run queue between front and back
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/lrle_back.sv]
module lrle_back import lrle_pkg::*; #(
  parameter int NUM_DIGITS = 5,
  parameter int DIG_W      = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  lrle_tag_t                   head_tag_i,
  input  logic [NUM_DIGITS-1:0][3:0]  head_digits_i,
  input  logic [DIG_W-1:0]            head_ndig_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_byte_o,
  output logic                        last_of_item_o,
  output logic                        string_done_o
);

  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             last_q, done_q;
  // letter sent, digits left to send
  logic             sent_q;
  logic [DIG_W-1:0] idx_q;

  logic             can_load, step, fin;
  logic [3:0]       digit;
  logic [7:0]       byte_d;

  assign can_load = ~out_valid_q | ~out_stall_i;
  assign step     = head_valid_i & can_load;

  // pick the next digit, most significant first
  always_comb begin
    digit = 4'd0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (DIG_W'(i) == (idx_q - DIG_W'(1))) begin
        digit = head_digits_i[i];
      end
    end
    if (!sent_q) begin
      byte_d = head_tag_i.letter;
      fin    = (head_ndig_i == '0);
    end else begin
      byte_d = CHAR_ZERO + {4'd0, digit};
      fin    = (idx_q == DIG_W'(1));
    end
  end

  assign pop_o = step & fin;

  // sequencing and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_q      <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (step) begin
        out_valid_q <= 1'b1;
        if (fin) begin
          sent_q <= 1'b0;
          idx_q  <= '0;
        end else if (!sent_q) begin
          sent_q <= 1'b1;
          idx_q  <= head_ndig_i;
        end else begin
          idx_q <= idx_q - DIG_W'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q <= byte_d;
      last_q     <= fin & head_tag_i.last;
      done_q     <= fin & head_tag_i.done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_of_item_o = last_q;
  assign string_done_o  = done_q;

endmodule

[rtl/letter_run_length_encoder_top.sv]
// letter run-length encoder
// input channel: one string byte per request (in_byte_i) with end_of_string_i
// on the final byte; in_valid_i / in_stall_o handshake
// output channel: one encoded byte per request (out_byte_o), the run letter
// followed by its length in ascii decimal, most significant digit first, when
// the run is longer than one; last_of_item_o marks the last byte caused by an
// input request, string_done_o the last byte of the encoded string
// non-letter bytes are dropped and close the open run; the count saturates
// at 2**COUNT_BITS - 1
// the front takes one input request per cycle, unless in_stall_o is high, and
// classifies it, keeping the run count in binary and in bcd; a request that
// closes a run and also ends the string with a new letter stalls the input
// until its second run is queued; a two-entry run queue feeds the back,
// which sends 1 + digit count bytes per run, one byte per cycle when not stalled
// the first output byte of a run enters the run queue when the request
// closing the run is accepted, and then the output register of the back
// reset clears the open run, the run queue and the output valid bit
// a stalled output holds its byte; the queue fills, then the input stalls
`include "letter_run_length_encoder_top_defines.svh"

module letter_run_length_encoder_top import lrle_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_item_o,
  output logic       string_done_o
);

  localparam int NUM_DIGITS = dec_digits(COUNT_BITS);
  localparam int DIG_W      = $clog2(NUM_DIGITS + 1);
  localparam int Q_WIDTH    = $bits(lrle_tag_t) + NUM_DIGITS * 4 + DIG_W;

  logic                       fq_push, fq_full, fq_valid, fq_pop;
  lrle_tag_t                  push_tag, head_tag;
  logic [NUM_DIGITS-1:0][3:0] push_digits, head_digits;
  logic [DIG_W-1:0]           push_ndig, head_ndig;
  logic [Q_WIDTH-1:0]         fq_wdata, fq_rdata;

  // request classification and run counting
  lrle_front #(
    .COUNT_BITS (COUNT_BITS),
    .NUM_DIGITS (NUM_DIGITS),
    .DIG_W      (DIG_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .push_o          (fq_push),
    .push_full_i     (fq_full),
    .push_tag_o      (push_tag),
    .push_digits_o   (push_digits),
    .push_ndig_o     (push_ndig)
  );

  // closed runs waiting for the back
  assign fq_wdata = {push_tag, push_digits, push_ndig};
  assign {head_tag, head_digits, head_ndig} = fq_rdata;

  lrle_queue #(
    .WIDTH (Q_WIDTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fq_push),
    .push_data_i (fq_wdata),
    .full_o      (fq_full),
    .valid_o     (fq_valid),
    .data_o      (fq_rdata),
    .pop_i       (fq_pop)
  );

  // byte serializer
  lrle_back #(
    .NUM_DIGITS (NUM_DIGITS),
    .DIG_W      (DIG_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (fq_valid),
    .head_tag_i     (head_tag),
    .head_digits_i  (head_digits),
    .head_ndig_i    (head_ndig),
    .pop_o          (fq_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_item_o (last_of_item_o),
    .string_done_o  (string_done_o)
  );

  // queue never overflows or underflows, end of string closes an item
  `LRLE_ASSERT_NEVER(a_push_when_full, clk_i, rst_ni, fq_push && fq_full)
  `LRLE_ASSERT_NEVER(a_pop_when_empty, clk_i, rst_ni, fq_pop && !fq_valid)
  `LRLE_ASSERT(a_done_is_last, clk_i, rst_ni, (out_valid_o && string_done_o) |-> last_of_item_o)

endmodule

[tb/tb_top.sv]
module tb_top import lrle_pkg::*; ();

  localparam int CNT_BITS      = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_ITEMS    = 25;
  localparam int STALL_LIMIT   = 5000;
  localparam int TAIL_CYCLES   = 20;
  localparam int PHASE_ITEMS   = 30;

  // one encoded output byte
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       done;
  } enc_byte_t;

  // one row of the directed table; text, when not empty, is the typed-in output
  typedef struct {
    logic [7:0] chr;
    logic       eos;
    int         reps;
    string      text;
  } str_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       end_of_string_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_item_o;
  logic       string_done_o;

  // encoder state as seen by the predictor
  logic [7:0]          run_chr;
  logic [CNT_BITS-1:0] run_cnt;
  logic                run_open;

  enc_byte_t step_q[$];
  enc_byte_t pending_q[$];
  enc_byte_t got_exp;

  int n_errors    = 0;
  int n_items     = 0;
  int snd_pct     = 0;
  int rcv_pct     = 0;
  int hold_reqs   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int quiet_count = 0;

  str_row_t dir_tab [0:22] = '{
    '{8'h41, 1'b1, 1, "A"},
    '{8'h7A, 1'b1, 1, "z"},
    '{8'h5A, 1'b0, 4, ""},
    '{8'h5A, 1'b1, 1, "Z5"},
    '{8'h61, 1'b0, 9, ""},
    '{8'h61, 1'b1, 1, "a10"},
    '{8'h40, 1'b1, 1, ""},
    '{8'h5B, 1'b0, 1, ""},
    '{8'h60, 1'b0, 1, ""},
    '{8'h7B, 1'b0, 1, ""},
    '{8'h00, 1'b0, 1, ""},
    '{8'hFF, 1'b0, 1, ""},
    '{8'h80, 1'b1, 1, ""},
    '{8'h62, 1'b0, 3, ""},
    '{8'h42, 1'b0, 1, ""},
    '{8'h7F, 1'b0, 1, ""},
    '{8'h63, 1'b0, 2, ""},
    '{8'h64, 1'b1, 1, ""},
    '{8'h6B, 1'b0, 2, ""},
    '{8'h35, 1'b1, 1, "k2"},
    '{8'h71, 1'b0, 11, ""},
    '{8'h73, 1'b1, 1, "q11s"},
    '{8'h4D, 1'b1, 1, "M"}
  };

  letter_run_length_encoder_top #(
    .COUNT_BITS(CNT_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_item_o (last_of_item_o),
    .string_done_o  (string_done_o)
  );

  // clock
  always #4 clk_i = ~clk_i;

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
           (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z);
  endfunction

  // emit the open run: letter, then decimal count when longer than one
  task automatic close_run();
    logic [3:0] dig [0:9];
    int         v;
    int         nd;
    v  = int'(run_cnt);
    nd = 0;
    step_q.push_back('{code: run_chr, last: 1'b0, done: 1'b0});
    if (run_cnt > 1) begin
      while (v > 0) begin
        dig[nd] = 4'(v % 10);
        v       = v / 10;
        nd++;
      end
      for (int i = nd - 1; i >= 0; i--) begin
        step_q.push_back('{code: CHAR_ZERO + 8'(dig[i]), last: 1'b0, done: 1'b0});
      end
    end
    run_open = 1'b0;
    run_chr  = '0;
    run_cnt  = '0;
  endtask

  // bytes produced by one input request, left in step_q
  task automatic encode_step(input logic [7:0] b, input logic e);
    bit alpha;
    alpha = is_alpha(b);
    step_q.delete();
    if (run_open && (!alpha || b != run_chr)) close_run();
    if (alpha) begin
      if (run_open) begin
        if (run_cnt != '1) run_cnt = run_cnt + 1'b1;
      end else begin
        run_chr  = b;
        run_cnt  = CNT_BITS'(1);
        run_open = 1'b1;
      end
    end
    if (e) begin
      if (run_open) close_run();
      run_open = 1'b0;
      run_chr  = '0;
      run_cnt  = '0;
    end
    if (step_q.size() > 0) begin
      step_q[step_q.size()-1].last = 1'b1;
      if (e) step_q[step_q.size()-1].done = 1'b1;
    end
  endtask

  // offer one request, wait for it to be taken, then queue its bytes
  task automatic send_byte(input logic [7:0] b, input logic e, input string text);
    while ($urandom_range(0, 99) < snd_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_byte_i       <= b;
    end_of_string_i <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    encode_step(b, e);
    if (text.len() > 0) begin
      for (int i = 0; i < text.len(); i++) begin
        pending_q.push_back('{code: text[i], last: (i == text.len() - 1),
                              done: (i == text.len() - 1) && e});
      end
    end else begin
      foreach (step_q[i]) pending_q.push_back(step_q[i]);
    end
    n_items++;
  endtask

  // a string of letter runs with some stray bytes mixed in
  task automatic send_random_string();
    int         nruns;
    int         len;
    logic [7:0] chr;
    bit         noise;
    nruns = $urandom_range(1, 6);
    for (int r = 0; r < nruns; r++) begin
      noise = ($urandom_range(0, 9) == 0);
      if (noise) begin
        chr = 8'($urandom_range(0, 255));
        len = 1;
      end else begin
        if ($urandom_range(0, 1) == 0) chr = CHAR_UPPER_A + 8'($urandom_range(0, 25));
        else chr = CHAR_LOWER_A + 8'($urandom_range(0, 25));
        case ($urandom_range(0, 39))
          0:             len = $urandom_range(10, 120);
          1, 2, 3:       len = $urandom_range(10, 14);
          4, 5, 6, 7, 8,
          9, 10, 11:     len = $urandom_range(2, 9);
          default:       len = 1;
        endcase
      end
      for (int i = 0; i < len; i++) begin
        send_byte(chr, (r == nruns - 1) && (i == len - 1), "");
      end
    end
  endtask

  // stop offering and wait for every queued byte to come out
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() > 0) @(posedge clk_i);
  endtask

  // receiver stall: long hold-off on request, else random
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen   = hold_reqs;
      hold_left   = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rcv_pct);
    end
  end

  // compare each output byte with the oldest queued one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        n_errors++;
        $display("%0t: out_byte expected nothing actual %h last %b done %b", $time,
                 out_byte_o, last_of_item_o, string_done_o);
      end else begin
        got_exp = pending_q.pop_front();
        if (out_byte_o !== got_exp.code) begin
          n_errors++;
          $display("%0t: out_byte expected %h actual %h", $time, got_exp.code, out_byte_o);
        end
        if (last_of_item_o !== got_exp.last) begin
          n_errors++;
          $display("%0t: last_of_item expected %b actual %b", $time, got_exp.last,
                   last_of_item_o);
        end
        if (string_done_o !== got_exp.done) begin
          n_errors++;
          $display("%0t: string_done expected %b actual %b", $time, got_exp.done,
                   string_done_o);
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
    end
    if (quiet_count >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_count);
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus
  initial begin
    int phase_start;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_byte_i       = '0;
    end_of_string_i = 1'b0;
    run_chr         = '0;
    run_cnt         = '0;
    run_open        = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_tab[r]) begin
      for (int i = 0; i < dir_tab[r].reps; i++) begin
        send_byte(dir_tab[r].chr, dir_tab[r].eos, dir_tab[r].text);
      end
    end
    wait_drain();

    // receiver holds off while the sender keeps offering
    phase_start = n_items;
    hold_reqs++;
    while (n_items - phase_start < HOLD_ITEMS) send_random_string();
    wait_drain();

    // random strings under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 84; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 84; end
        default: begin snd_pct = 22; rcv_pct = 22; end
      endcase
      phase_start = n_items;
      while (n_items - phase_start < PHASE_ITEMS) send_random_string();
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
